// ===== hdl/tllc_pkg.sv =====
package tllc_pkg;

  localparam int unsigned NumCounters = 7;
  localparam int unsigned CountWidth  = 48;

  typedef enum logic [2:0] {
    CntReads     = 3'd0,
    CntWrites    = 3'd1,
    CntL1Hits    = 3'd2,
    CntL1Misses  = 3'd3,
    CntL2Hits    = 3'd4,
    CntL2Misses  = 3'd5,
    CntWritebks  = 3'd6
  } cnt_sel_e;

  // back-end sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StL1Read,
    StL1Check,
    StL2Read,
    StL2Check,
    StVicRead,
    StVicCheck,
    StL1Write,
    StOut
  } be_state_e;

endpackage

// ===== hdl/tllc_if.sv =====
interface tllc_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/two_level_lru_writeback_cache.sv =====
// Two-level tag-only cache model with LRU replacement and write-back.
// Request channel req_i carries {address, store flag, batch start}; result
// channel rsp_o carries {l1_hit, l2_hit, l2_miss, writebacks_now, seven
// 48-bit counters: reads, writes, l1 hits, l1 misses, l2 hits, l2 misses,
// writebacks}. Both use valid/ready; a request is taken when both are high.
// A two-entry queue holds requests while the back end works on one.
// Each request walks the set rows one at a time through the set RAMs
// (one read and one write port each). A request passes through L1Read and
// L1Check, then Out, which loads the result register; a miss adds L2Read,
// L2Check and L1Write, and a dirty victim also VicRead and VicCheck.
// The back end takes its next request at the earliest in the cycle after the
// result is taken, so it finishes one request before it starts the next; the
// set read-modify-write sequence through the set RAMs sets the rate.
// After reset a clearing pass over every set of the larger level initialises
// both tag stores; requests queue but are not processed until it ends.
// If the receiver stalls, the result is held and the back end waits;
// the queue still accepts up to two requests.
module two_level_lru_writeback_cache #(
  parameter int unsigned NEAR_SETS  = 64,
  parameter int unsigned FAR_SETS   = 512,
  parameter int unsigned ASSOC      = 8,
  parameter int unsigned LINE_SHIFT = 6,
  parameter int unsigned ADDR_WIDTH = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  tllc_if.sink   req_i,
  tllc_if.source rsp_o
);

  tllc_if #(.Width(ADDR_WIDTH - LINE_SHIFT + 2)) q_if ();

  tllc_front #(.ADDR_WIDTH(ADDR_WIDTH), .LINE_SHIFT(LINE_SHIFT)) u_front (
    .clk_i, .rst_ni, .req_i(req_i), .q_o(q_if.source));

  tllc_back #(
    .NEAR_SETS(NEAR_SETS), .FAR_SETS(FAR_SETS), .ASSOC(ASSOC),
    .ADDR_WIDTH(ADDR_WIDTH), .LINE_SHIFT(LINE_SHIFT)
  ) u_back (
    .clk_i, .rst_ni, .q_i(q_if.sink), .rsp_o(rsp_o));

endmodule

// ===== hdl/tllc_ram.sv =====
module tllc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/tllc_front.sv =====
module tllc_front #(
  parameter int unsigned ADDR_WIDTH = 48,
  parameter int unsigned LINE_SHIFT = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  tllc_if.sink   req_i,
  tllc_if.source q_o
);

  localparam int unsigned BlockWidth = ADDR_WIDTH - LINE_SHIFT;
  localparam int unsigned QWidth = BlockWidth + 2;
  localparam int unsigned Depth = 2;

  logic [QWidth-1:0] fifo_q [Depth];
  logic              wptr_q, rptr_q;
  logic [1:0]        cnt_q;
  logic              push, pop;

  // request queue: line number, store flag and batch start
  assign req_i.ready = (cnt_q != 2'd2);
  assign push = req_i.valid && req_i.ready;
  assign pop  = q_o.valid && q_o.ready;
  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.data  = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= {req_i.data[ADDR_WIDTH+1:LINE_SHIFT+2], req_i.data[1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost an entry");
  a_empty_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");

endmodule

// ===== hdl/tllc_back.sv =====
module tllc_back #(
  parameter int unsigned NEAR_SETS  = 64,
  parameter int unsigned FAR_SETS   = 512,
  parameter int unsigned ASSOC      = 8,
  parameter int unsigned ADDR_WIDTH = 48,
  parameter int unsigned LINE_SHIFT = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  tllc_if.sink   q_i,
  tllc_if.source rsp_o
);

  localparam int unsigned BW  = ADDR_WIDTH - LINE_SHIFT;
  localparam int unsigned NSW = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1;
  localparam int unsigned FSW = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1;
  localparam int unsigned WW  = $clog2(ASSOC);
  localparam int unsigned NTW = BW - NSW;
  localparam int unsigned FTW = BW - FSW;
  localparam int unsigned OW  = ASSOC * WW;
  localparam int unsigned NRW = ASSOC * (NTW + 2) + OW;
  localparam int unsigned FRW = ASSOC * (FTW + 2) + OW;
  localparam int unsigned CW  = tllc_pkg::CountWidth;
  localparam int unsigned NC  = tllc_pkg::NumCounters;
  localparam logic [CW-1:0] CntMax = '1;
  // the clearing pass covers the larger of the two levels
  localparam int unsigned ClrSets = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
  localparam int unsigned CLW     = $clog2(ClrSets) + 1;

  // set row layout: {order, dirty, valid, tags}
  typedef struct packed {
    logic [OW-1:0]      order;
    logic [ASSOC-1:0]   dirty;
    logic [ASSOC-1:0]   valid;
    logic [ASSOC*NTW-1:0] tags;
  } nrow_t;
  typedef struct packed {
    logic [OW-1:0]      order;
    logic [ASSOC-1:0]   dirty;
    logic [ASSOC-1:0]   valid;
    logic [ASSOC*FTW-1:0] tags;
  } frow_t;

  tllc_pkg::be_state_e state_q, state_d;

  logic [BW-1:0]  blk_q;
  logic           wr_q, bs_q;
  logic           l1h_q, l2h_q, l2m_q;
  logic [1:0]     wbn_q;
  logic [BW-1:0]  vblk_q;
  logic           vdirty_q;
  logic [WW-1:0]  nvic_q;
  nrow_t          nrow_q;
  logic [CW-1:0]  cnt_q [NC];
  logic [CW-1:0]  cnt_d [NC];
  logic           out_v_q;
  logic [3+2+NC*CW-1:0] out_q;

  // clearing pass over both tag stores
  logic           clr_q;
  logic [CLW-1:0] clr_cnt_q;

  // memories
  logic           nwe, fwe;
  logic [NSW-1:0] nwa, nra;
  logic [FSW-1:0] fwa, fra;
  nrow_t          nwd, nrd;
  frow_t          fwd, frd;

  tllc_ram #(.Width(NRW), .Depth(NEAR_SETS)) u_near (
    .clk_i, .we_i(nwe), .waddr_i(nwa), .wdata_i(nwd), .raddr_i(nra), .rdata_o(nrd));
  tllc_ram #(.Width(FRW), .Depth(FAR_SETS)) u_far (
    .clk_i, .we_i(fwe), .waddr_i(fwa), .wdata_i(fwd), .raddr_i(fra), .rdata_o(frd));

  // move way w to the front of the order list
  function automatic logic [OW-1:0] touch(logic [OW-1:0] o, logic [WW-1:0] w);
    logic [OW-1:0] r;
    logic          seen;
    r = o;
    seen = 1'b0;
    for (int i = 0; i < ASSOC; i++) begin
      if (i > 0 && !seen) r[i*WW +: WW] = o[(i-1)*WW +: WW];
      if (o[i*WW +: WW] == w) seen = 1'b1;
    end
    r[WW-1:0] = w;
    return r;
  endfunction

  function automatic logic [OW-1:0] reset_order();
    logic [OW-1:0] r;
    for (int i = 0; i < ASSOC; i++) r[i*WW +: WW] = WW'(i);
    return r;
  endfunction

  // victim: lowest invalid way, else LRU
  function automatic logic [WW-1:0] victim(logic [ASSOC-1:0] v, logic [OW-1:0] o);
    logic [WW-1:0] r;
    logic          f;
    r = o[(ASSOC-1)*WW +: WW];
    f = 1'b0;
    for (int i = 0; i < ASSOC; i++) begin
      if (!v[i] && !f) begin
        r = WW'(i);
        f = 1'b1;
      end
    end
    return r;
  endfunction

  // near lookup
  logic [NTW-1:0] ntag;
  logic [NSW-1:0] nset;
  logic           nhit;
  logic [WW-1:0]  nway;
  assign nset = blk_q[NSW-1:0];
  assign ntag = blk_q[BW-1:NSW];
  always_comb begin
    nhit = 1'b0;
    nway = '0;
    for (int i = ASSOC-1; i >= 0; i--) begin
      if (nrd.valid[i] && nrd.tags[i*NTW +: NTW] == ntag) begin
        nhit = 1'b1;
        nway = WW'(i);
      end
    end
  end

  // far lookup for the demand block or the victim block
  logic [BW-1:0]  fblk;
  logic [FTW-1:0] ftag;
  logic           fhit;
  logic [WW-1:0]  fway, fvic;
  logic           fvic_dirty;
  assign fblk = (state_q == tllc_pkg::StVicCheck) ? vblk_q : blk_q;
  assign ftag = fblk[BW-1:FSW];
  always_comb begin
    fhit = 1'b0;
    fway = '0;
    for (int i = ASSOC-1; i >= 0; i--) begin
      if (frd.valid[i] && frd.tags[i*FTW +: FTW] == ftag) begin
        fhit = 1'b1;
        fway = WW'(i);
      end
    end
  end
  assign fvic = victim(frd.valid, frd.order);
  assign fvic_dirty = frd.valid[fvic] && frd.dirty[fvic];

  logic [WW-1:0]  nvic;
  assign nvic = victim(nrd.valid, nrd.order);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tllc_pkg::StIdle:     if (q_i.valid && !clr_q && !out_v_q) state_d = tllc_pkg::StL1Read;
      tllc_pkg::StL1Read:   state_d = tllc_pkg::StL1Check;
      tllc_pkg::StL1Check:  state_d = nhit ? tllc_pkg::StOut : tllc_pkg::StL2Read;
      tllc_pkg::StL2Read:   state_d = tllc_pkg::StL2Check;
      tllc_pkg::StL2Check:  state_d = vdirty_q ? tllc_pkg::StVicRead : tllc_pkg::StL1Write;
      tllc_pkg::StVicRead:  state_d = tllc_pkg::StVicCheck;
      tllc_pkg::StVicCheck: state_d = tllc_pkg::StL1Write;
      tllc_pkg::StL1Write:  state_d = tllc_pkg::StOut;
      tllc_pkg::StOut:      state_d = tllc_pkg::StIdle;
      default:              state_d = tllc_pkg::StIdle;
    endcase
  end

  // memory control
  always_comb begin
    nwe = 1'b0;
    nwa = nset;
    nwd = nrow_q;
    nra = nset;
    fwe = 1'b0;
    fwa = blk_q[FSW-1:0];
    fwd = frd;
    fra = blk_q[FSW-1:0];
    q_i.ready = 1'b0;
    if (clr_q) begin
      nwe = (clr_cnt_q < CLW'(NEAR_SETS));
      nwa = clr_cnt_q[NSW-1:0];
      nwd = '{order: reset_order(), dirty: '0, valid: '0, tags: '0};
      fwe = (clr_cnt_q < CLW'(FAR_SETS));
      fwa = clr_cnt_q[FSW-1:0];
      fwd = '{order: reset_order(), dirty: '0, valid: '0, tags: '0};
    end else begin
      case (state_q)
        tllc_pkg::StIdle: begin
          q_i.ready = !out_v_q;
          nra = q_i.data[NSW+1:2];
        end
        tllc_pkg::StL1Check: begin
          if (nhit) begin
            nwe = 1'b1;
            nwd = nrd;
            nwd.order = touch(nrd.order, nway);
            if (wr_q) nwd.dirty[nway] = 1'b1;
          end
        end
        tllc_pkg::StL2Check: begin
          fwe = 1'b1;
          fwd = frd;
          if (fhit) begin
            fwd.order = touch(frd.order, fway);
          end else begin
            fwd.tags[fvic*FTW +: FTW] = ftag;
            fwd.valid[fvic] = 1'b1;
            fwd.dirty[fvic] = 1'b0;
            fwd.order = touch(frd.order, fvic);
          end
        end
        tllc_pkg::StVicRead: fra = vblk_q[FSW-1:0];
        tllc_pkg::StVicCheck: begin
          fwe = 1'b1;
          fwa = vblk_q[FSW-1:0];
          fwd = frd;
          if (fhit) begin
            fwd.dirty[fway] = 1'b1;
          end else begin
            fwd.tags[fvic*FTW +: FTW] = ftag;
            fwd.valid[fvic] = 1'b1;
            fwd.dirty[fvic] = 1'b1;
            fwd.order = touch(frd.order, fvic);
          end
        end
        tllc_pkg::StL1Write: begin
          nwe = 1'b1;
          nwd = nrow_q;
          nwd.tags[nvic_q*NTW +: NTW] = ntag;
          nwd.valid[nvic_q] = 1'b1;
          nwd.dirty[nvic_q] = wr_q;
          nwd.order = touch(nrow_q.order, nvic_q);
        end
        default: ;
      endcase
    end
  end

  // counters, updated once per request when it is finished
  always_comb begin
    for (int i = 0; i < NC; i++) cnt_d[i] = bs_q ? '0 : cnt_q[i];
    if (cnt_d[wr_q ? tllc_pkg::CntWrites : tllc_pkg::CntReads] != CntMax)
      cnt_d[wr_q ? tllc_pkg::CntWrites : tllc_pkg::CntReads] =
        cnt_d[wr_q ? tllc_pkg::CntWrites : tllc_pkg::CntReads] + 1'b1;
    if (l1h_q && cnt_d[tllc_pkg::CntL1Hits] != CntMax)
      cnt_d[tllc_pkg::CntL1Hits] = cnt_d[tllc_pkg::CntL1Hits] + 1'b1;
    if (!l1h_q && cnt_d[tllc_pkg::CntL1Misses] != CntMax)
      cnt_d[tllc_pkg::CntL1Misses] = cnt_d[tllc_pkg::CntL1Misses] + 1'b1;
    if (l2h_q && cnt_d[tllc_pkg::CntL2Hits] != CntMax)
      cnt_d[tllc_pkg::CntL2Hits] = cnt_d[tllc_pkg::CntL2Hits] + 1'b1;
    if (l2m_q && cnt_d[tllc_pkg::CntL2Misses] != CntMax)
      cnt_d[tllc_pkg::CntL2Misses] = cnt_d[tllc_pkg::CntL2Misses] + 1'b1;
    if (cnt_d[tllc_pkg::CntWritebks] > CntMax - CW'(wbn_q))
      cnt_d[tllc_pkg::CntWritebks] = CntMax;
    else
      cnt_d[tllc_pkg::CntWritebks] = cnt_d[tllc_pkg::CntWritebks] + CW'(wbn_q);
  end

  // request registers and outcome flags
  always_ff @(posedge clk_i) begin
    case (state_q)
      tllc_pkg::StIdle: begin
        blk_q <= q_i.data[BW+1:2];
        wr_q  <= q_i.data[1];
        bs_q  <= q_i.data[0];
        l1h_q <= 1'b0;
        l2h_q <= 1'b0;
        l2m_q <= 1'b0;
        wbn_q <= 2'd0;
      end
      tllc_pkg::StL1Check: begin
        l1h_q    <= nhit;
        nrow_q   <= nrd;
        nvic_q   <= nvic;
        vdirty_q <= nrd.valid[nvic] && nrd.dirty[nvic];
        vblk_q   <= {nrd.tags[nvic*NTW +: NTW], nset};
      end
      tllc_pkg::StL2Check: begin
        l2h_q <= fhit;
        l2m_q <= !fhit;
        wbn_q <= {1'b0, !fhit && fvic_dirty};
      end
      tllc_pkg::StVicCheck: begin
        if (!fhit && fvic_dirty) wbn_q <= wbn_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tllc_pkg::StIdle;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      out_v_q   <= 1'b0;
      for (int i = 0; i < NC; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLW'(ClrSets - 1)) clr_q <= 1'b0;
      end
      if (state_q == tllc_pkg::StOut) begin
        for (int i = 0; i < NC; i++) cnt_q[i] <= cnt_d[i];
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == tllc_pkg::StOut) begin
      out_q <= {l1h_q, l2h_q, l2m_q, wbn_q, cnt_d[0], cnt_d[1], cnt_d[2], cnt_d[3],
                cnt_d[4], cnt_d[5], cnt_d[6]};
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $countones(out_q[3+2+NC*CW-1 -: 3]) == 1) else $error("outcome not unique");
  a_no_wb_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q[3+2+NC*CW-1] |-> out_q[NC*CW +: 2] == 2'd0)
    else $error("writeback on first-level hit");
  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> state_q == tllc_pkg::StIdle) else $error("request during clearing pass");

endmodule
